### rtl/core/afrm_pkg.sv
// Shared constants for the animation frame timer: field widths, the Q0.16 unit
// and the configuration register indexes.
// No dependencies.
package afrm_pkg;

   localparam int TIME_W  = 32;   // millisecond time stamps
   localparam int HALF_W  = 16;   // frame indexes, spans, frame times, fractions
   localparam int FRAME_W = 17;   // frame results and Q0.16 weights
   localparam int IDX_W   = 3;    // configuration register index
   localparam int DIVQ_W  = TIME_W + HALF_W;  // quotient register: {count, fraction}
   localparam int CNT_W   = 6;

   localparam logic [FRAME_W-1:0] Q16_ONE  = 17'h10000;
   localparam logic [FRAME_W-1:0] Q16_ZERO = 17'h00000;

   localparam logic [CNT_W-1:0] DIV_STEPS = 6'd47;  // 48 quotient bits, minus one
   localparam logic [CNT_W-1:0] MOD_STEPS = 6'd31;  // 32 dividend bits, minus one

   localparam logic [IDX_W-1:0] REG_START_TIME = 3'd0;
   localparam logic [IDX_W-1:0] REG_FIRST      = 3'd1;
   localparam logic [IDX_W-1:0] REG_SPAN       = 3'd2;
   localparam logic [IDX_W-1:0] REG_FRAME_TIME = 3'd3;
   localparam logic [IDX_W-1:0] REG_LOOPING    = 3'd4;

endpackage

### rtl/core/animation_frame_timer.sv
// Animation frame timer: frame selection and Q0.16 backward interpolation weight.
// Depends on afrm_pkg.
//
// Each item carries the current time in ms. A single restoring divider (one
// 17-bit subtract and compare per cycle) divides the elapsed time, extended by
// 16 fraction bits, by the frame time in 48 steps, giving the frame count and
// the Q0.16 fraction. When a looping animation runs past its last frame, the
// same unit takes the frame count modulo the span in 32 more steps. When the
// time is not past the start or the span is empty, an item skips the divider
// and goes straight to the final state, which holds while a full output
// register is stalled. req_stall is high while an item is in work; a finished
// result waits in the output register and the next item is taken meanwhile.
// Configuration is accepted every cycle and must only be written while the
// block is idle.
module animation_frame_timer (
   input  logic                            clock,
   input  logic                            reset,
   // input items
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [afrm_pkg::TIME_W-1:0]     req_now_ms,
   // result items
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [afrm_pkg::FRAME_W-1:0]    rsp_current_frame,
   output logic [afrm_pkg::FRAME_W-1:0]    rsp_old_frame,
   output logic [afrm_pkg::FRAME_W-1:0]    rsp_back_lerp,
   output logic                            rsp_done_res,
   // configuration writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [afrm_pkg::IDX_W-1:0]      csr_index,
   input  logic [afrm_pkg::TIME_W-1:0]     csr_wdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_MOD, ST_FIN} state_type;

   state_type state_ff;

   // configuration
   logic [afrm_pkg::TIME_W-1:0]  start_time_ff;
   logic [afrm_pkg::HALF_W-1:0]  first_ff;
   logic [afrm_pkg::HALF_W-1:0]  span_ff;
   logic [afrm_pkg::HALF_W-1:0]  frame_time_ff;
   logic                         looping_ff;

   // divider and sequencer datapath
   logic [afrm_pkg::HALF_W-1:0]  r_ff;
   logic [afrm_pkg::HALF_W-1:0]  d_ff;
   logic [afrm_pkg::DIVQ_W-1:0]  q_ff;
   logic [afrm_pkg::CNT_W-1:0]   cnt_ff;
   logic [afrm_pkg::HALF_W-1:0]  frac_ff;
   logic [afrm_pkg::FRAME_W-1:0] cur_ff;
   logic [afrm_pkg::FRAME_W-1:0] shown_ff;

   // output register
   logic                         rsp_valid_ff;
   logic [afrm_pkg::FRAME_W-1:0] rsp_cur_ff;
   logic [afrm_pkg::FRAME_W-1:0] rsp_old_ff;
   logic [afrm_pkg::FRAME_W-1:0] rsp_lerp_ff;
   logic                         rsp_done_ff;

   logic                         req_take;
   logic                         fast_path;
   logic [afrm_pkg::TIME_W-1:0]  elapsed;
   logic [afrm_pkg::HALF_W-1:0]  ft_eff;
   logic [afrm_pkg::HALF_W:0]    shifted;
   logic                         ge;
   logic [afrm_pkg::HALF_W:0]    diff;
   logic [afrm_pkg::HALF_W-1:0]  r_in;
   logic [afrm_pkg::DIVQ_W-1:0]  q_in;
   logic [afrm_pkg::TIME_W-1:0]  k_val;
   logic                         past_end;
   logic [afrm_pkg::FRAME_W-1:0] first_ext;
   logic [afrm_pkg::FRAME_W-1:0] last_val;
   logic [afrm_pkg::FRAME_W-1:0] old_in;
   logic [afrm_pkg::FRAME_W-1:0] lerp_in;
   logic                         fin_load;

   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign elapsed   = req_now_ms - start_time_ff;
   assign fast_path = (req_now_ms <= start_time_ff) || (span_ff == '0);
   assign ft_eff    = (frame_time_ff == '0) ? afrm_pkg::HALF_W'(1) : frame_time_ff;

   // one restoring division step
   assign shifted = {r_ff, q_ff[afrm_pkg::DIVQ_W-1]};
   assign ge      = (shifted >= {1'b0, d_ff});
   assign diff    = shifted - {1'b0, d_ff};
   assign r_in    = ge ? diff[afrm_pkg::HALF_W-1:0] : shifted[afrm_pkg::HALF_W-1:0];
   assign q_in    = {q_ff[afrm_pkg::DIVQ_W-2:0], ge};

   assign k_val     = q_in[afrm_pkg::DIVQ_W-1:afrm_pkg::HALF_W];
   assign past_end  = (k_val > {{(afrm_pkg::TIME_W-afrm_pkg::HALF_W){1'b0}}, span_ff});
   assign first_ext = {1'b0, first_ff};
   assign last_val  = first_ext + {1'b0, span_ff};

   always_comb begin
      if ((cur_ff > first_ext) && (cur_ff <= last_val)) begin
         old_in = cur_ff - afrm_pkg::FRAME_W'(1);
      end else begin
         old_in = shown_ff;
      end
      if (cur_ff == first_ext) begin
         lerp_in = afrm_pkg::Q16_ZERO;
      end else if (cur_ff == last_val) begin
         lerp_in = afrm_pkg::Q16_ONE;
      end else begin
         lerp_in = afrm_pkg::Q16_ONE - {1'b0, frac_ff};
      end
   end

   assign fin_load = (state_ff == ST_FIN) && !(rsp_valid_ff && rsp_stall);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff <= '0;
         first_ff      <= '0;
         span_ff       <= '0;
         frame_time_ff <= afrm_pkg::HALF_W'(1);
         looping_ff    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            afrm_pkg::REG_START_TIME: start_time_ff <= csr_wdata;
            afrm_pkg::REG_FIRST:      first_ff      <= csr_wdata[afrm_pkg::HALF_W-1:0];
            afrm_pkg::REG_SPAN:       span_ff       <= csr_wdata[afrm_pkg::HALF_W-1:0];
            afrm_pkg::REG_FRAME_TIME: frame_time_ff <= csr_wdata[afrm_pkg::HALF_W-1:0];
            afrm_pkg::REG_LOOPING:    looping_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // divider datapath, no reset needed
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               r_ff    <= '0;
               d_ff    <= ft_eff;
               q_ff    <= {elapsed, {afrm_pkg::HALF_W{1'b0}}};
               cnt_ff  <= afrm_pkg::DIV_STEPS;
               frac_ff <= '0;
               cur_ff  <= first_ext;
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               frac_ff <= q_in[afrm_pkg::HALF_W-1:0];
               // set up the wrap: k mod span
               r_ff    <= '0;
               d_ff    <= span_ff;
               q_ff    <= {k_val, {afrm_pkg::HALF_W{1'b0}}};
               cnt_ff  <= afrm_pkg::MOD_STEPS;
               if (!past_end) begin
                  cur_ff <= first_ext + k_val[afrm_pkg::FRAME_W-1:0];
               end else begin
                  cur_ff <= last_val - afrm_pkg::FRAME_W'(1);
               end
            end else begin
               r_ff   <= r_in;
               q_ff   <= q_in;
               cnt_ff <= cnt_ff - afrm_pkg::CNT_W'(1);
            end
         end
         ST_MOD: begin
            r_ff   <= r_in;
            q_ff   <= q_in;
            cnt_ff <= cnt_ff - afrm_pkg::CNT_W'(1);
            if (cnt_ff == '0) begin
               cur_ff <= first_ext + {1'b0, r_in};
            end
         end
         default: ;
      endcase
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         shown_ff     <= '0;
      end else begin
         if (fin_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  state_ff <= fast_path ? ST_FIN : ST_DIV;
               end
            end
            ST_DIV: begin
               if (cnt_ff == '0) begin
                  state_ff <= (past_end && looping_ff) ? ST_MOD : ST_FIN;
               end
            end
            ST_MOD: begin
               if (cnt_ff == '0) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               // hold until the output register is free
               if (fin_load) begin
                  rsp_cur_ff   <= cur_ff;
                  rsp_old_ff   <= old_in;
                  rsp_lerp_ff  <= lerp_in;
                  rsp_done_ff  <= (lerp_in == afrm_pkg::Q16_ONE);
                  shown_ff     <= cur_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_frame = rsp_cur_ff;
   assign rsp_old_frame     = rsp_old_ff;
   assign rsp_back_lerp     = rsp_lerp_ff;
   assign rsp_done_res      = rsp_done_ff;

   // the partial remainder stays below the divisor throughout a division
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV) || (state_ff == ST_MOD)) |-> (r_ff < d_ff))
      else $error("divider remainder not below divisor");

   // the wrap step never runs with an empty span
   a_mod_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD) |-> (d_ff != '0))
      else $error("modulo step with zero span");

   // a finished item lands in the output register and frees the input side
   a_fin_load: assert property (@(posedge clock) disable iff (reset)
      fin_load |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished item not delivered to output register");

   // the weight never exceeds one
   a_lerp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_lerp_ff <= afrm_pkg::Q16_ONE))
      else $error("back_lerp above 1.0");

endmodule

### sim/animation_frame_timer_tb.sv
// Testbench for animation_frame_timer: directed and random time stamps under several
// register settings, checked against a cycle-free frame predictor in a scoreboard.
// Depends on afrm_pkg and the animation_frame_timer RTL.

typedef struct packed {
   logic [afrm_pkg::FRAME_W-1:0] cur_frame;
   logic [afrm_pkg::FRAME_W-1:0] old_frame;
   logic [afrm_pkg::FRAME_W-1:0] back_lerp;
   logic                         done;
} frame_result_type;

class frame_scoreboard;
   logic [afrm_pkg::TIME_W-1:0]  start_ms;
   logic [afrm_pkg::HALF_W-1:0]  first;
   logic [afrm_pkg::HALF_W-1:0]  span;
   logic [afrm_pkg::HALF_W-1:0]  ftime;
   logic                         loop_en;
   logic [afrm_pkg::FRAME_W-1:0] shown;
   frame_result_type             frames_due[$];
   int                           errors;

   function new();
      start_ms = '0;
      first    = '0;
      span     = '0;
      ftime    = 16'd1;
      loop_en  = 1'b0;
      shown    = '0;
      errors   = 0;
   endfunction

   function void write_reg(logic [afrm_pkg::IDX_W-1:0] idx, logic [afrm_pkg::TIME_W-1:0] data);
      case (idx)
         afrm_pkg::REG_START_TIME: start_ms = data;
         afrm_pkg::REG_FIRST:      first    = data[afrm_pkg::HALF_W-1:0];
         afrm_pkg::REG_SPAN:       span     = data[afrm_pkg::HALF_W-1:0];
         afrm_pkg::REG_FRAME_TIME: ftime    = data[afrm_pkg::HALF_W-1:0];
         afrm_pkg::REG_LOOPING:    loop_en  = data[0];
         default: ;
      endcase
   endfunction

   // Work out the frame, old frame and weight for one accepted time stamp.
   function void note_update(logic [afrm_pkg::TIME_W-1:0] now);
      frame_result_type             want;
      logic [afrm_pkg::TIME_W-1:0]  ftw;
      logic [afrm_pkg::TIME_W-1:0]  elapsed;
      logic [afrm_pkg::TIME_W-1:0]  k;
      logic [afrm_pkg::TIME_W-1:0]  rem;
      logic [afrm_pkg::TIME_W-1:0]  cur32;
      logic [afrm_pkg::FRAME_W-1:0] last;
      logic [afrm_pkg::FRAME_W-1:0] frac;
      last = afrm_pkg::FRAME_W'(first) + afrm_pkg::FRAME_W'(span);
      ftw  = (ftime == '0) ? 32'd1 : 32'(ftime);
      if (now <= start_ms) begin
         cur32 = 32'(first);
         frac  = afrm_pkg::Q16_ZERO;
      end else if (span == '0) begin
         cur32 = 32'(first);
         frac  = afrm_pkg::Q16_ONE;
      end else begin
         elapsed = now - start_ms;
         k       = elapsed / ftw;
         rem     = elapsed % ftw;
         frac    = afrm_pkg::FRAME_W'({rem[afrm_pkg::HALF_W-1:0], 16'h0000} / ftw);
         if (k > 32'(span))
            cur32 = loop_en ? 32'(first) + (k % 32'(span)) : 32'(last) - 32'd1;
         else
            cur32 = 32'(first) + k;
      end
      want.cur_frame = cur32[afrm_pkg::FRAME_W-1:0];
      if (want.cur_frame > afrm_pkg::FRAME_W'(first) && want.cur_frame <= last)
         want.old_frame = want.cur_frame - 17'd1;
      else
         want.old_frame = shown;
      if (want.cur_frame == afrm_pkg::FRAME_W'(first))
         want.back_lerp = afrm_pkg::Q16_ZERO;
      else if (want.cur_frame == last)
         want.back_lerp = afrm_pkg::Q16_ONE;
      else
         want.back_lerp = (frac >= afrm_pkg::Q16_ONE) ?
                          afrm_pkg::Q16_ZERO : afrm_pkg::Q16_ONE - frac;
      want.done = (want.back_lerp >= afrm_pkg::Q16_ONE);
      shown = want.cur_frame;
      frames_due.push_back(want);
   endfunction

   function void check_field(string name, logic [afrm_pkg::FRAME_W-1:0] want,
                             logic [afrm_pkg::FRAME_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   function void check_frame(frame_result_type got);
      frame_result_type want;
      if (frames_due.size() == 0) begin
         $display("%0t: result with nothing pending, expected none, actual %h", $time, got);
         errors++;
         return;
      end
      want = frames_due.pop_front();
      check_field("current_frame", want.cur_frame, got.cur_frame);
      check_field("old_frame", want.old_frame, got.old_frame);
      check_field("back_lerp", want.back_lerp, got.back_lerp);
      check_field("done_res", afrm_pkg::FRAME_W'(want.done), afrm_pkg::FRAME_W'(got.done));
   endfunction

   function int pending();
      return frames_due.size();
   endfunction

   function void close();
      if (frames_due.size() != 0) begin
         $display("%0t: results missing, expected %0d more, actual 0",
                  $time, frames_due.size());
         errors++;
      end
   endfunction
endclass

module animation_frame_timer_tb;

   localparam logic [afrm_pkg::IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [afrm_pkg::IDX_W-1:0] REG_SPARE_LAST  = 3'd7;
   localparam int IDLE_LIMIT   = 5000;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 100;
   localparam int PHASES       = 24;
   localparam int PHASE_ITEMS  = 80;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [afrm_pkg::TIME_W-1:0]   req_now_ms;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [afrm_pkg::FRAME_W-1:0]  rsp_current_frame;
   logic [afrm_pkg::FRAME_W-1:0]  rsp_old_frame;
   logic [afrm_pkg::FRAME_W-1:0]  rsp_back_lerp;
   logic                          rsp_done_res;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [afrm_pkg::IDX_W-1:0]    csr_index;
   logic [afrm_pkg::TIME_W-1:0]   csr_wdata;

   frame_scoreboard sb;
   int  gap_pct;
   int  stall_pct;
   bit  calm;
   bit  long_hold_pending;
   int  idle_cycles;

   animation_frame_timer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_current_frame (rsp_current_frame),
      .rsp_old_frame     (rsp_old_frame),
      .rsp_back_lerp     (rsp_back_lerp),
      .rsp_done_res      (rsp_done_res),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Offer one item and hold it until the block takes it.
   task automatic send_item(logic [afrm_pkg::TIME_W-1:0] now);
      @(negedge clock);
      req_valid  <= 1'b1;
      req_now_ms <= now;
      do @(posedge clock); while (req_stall);
      sb.note_update(now);
   endtask

   task automatic idle_req(int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [afrm_pkg::IDX_W-1:0] idx,
                            logic [afrm_pkg::TIME_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(logic [afrm_pkg::TIME_W-1:0] start_v,
                             logic [afrm_pkg::HALF_W-1:0] first_v,
                             logic [afrm_pkg::HALF_W-1:0] span_v,
                             logic [afrm_pkg::HALF_W-1:0] ft_v,
                             logic loop_v);
      write_reg(afrm_pkg::REG_START_TIME, start_v);
      write_reg(afrm_pkg::REG_FIRST, {16'($urandom), first_v});
      write_reg(afrm_pkg::REG_SPAN, {16'($urandom), span_v});
      write_reg(afrm_pkg::REG_FRAME_TIME, {16'($urandom), ft_v});
      write_reg(afrm_pkg::REG_LOOPING, {31'($urandom), loop_v});
   endtask

   task automatic pick_config();
      logic [afrm_pkg::TIME_W-1:0] start_v;
      logic [afrm_pkg::HALF_W-1:0] first_v;
      logic [afrm_pkg::HALF_W-1:0] span_v;
      logic [afrm_pkg::HALF_W-1:0] ft_v;
      case ($urandom_range(0, 4))
         0:       start_v = '0;
         1:       start_v = '1;
         2, 3:    start_v = $urandom;
         default: start_v = $urandom_range(0, 5000);
      endcase
      case ($urandom_range(0, 4))
         0:       first_v = '0;
         1:       first_v = '1;
         2:       first_v = 16'($urandom);
         default: first_v = 16'($urandom_range(0, 300));
      endcase
      case ($urandom_range(0, 9))
         0:       span_v = '0;
         1:       span_v = 16'd1;
         2:       span_v = '1;
         3:       span_v = 16'($urandom);
         default: span_v = 16'($urandom_range(2, 24));
      endcase
      case ($urandom_range(0, 9))
         0:       ft_v = '0;
         1:       ft_v = 16'd1;
         2:       ft_v = '1;
         3:       ft_v = 16'($urandom);
         default: ft_v = 16'($urandom_range(1, 60));
      endcase
      set_config(start_v, first_v, span_v, ft_v, 1'($urandom));
      // out-of-range writes must leave everything alone
      if ($urandom_range(0, 2) == 0)
         write_reg(afrm_pkg::IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                   $urandom);
   endtask

   // Bias time stamps toward the animated window around the start time.
   function automatic logic [afrm_pkg::TIME_W-1:0] pick_now();
      logic [63:0]                 reach;
      logic [afrm_pkg::TIME_W-1:0] ftw;
      int unsigned                 sel;
      ftw   = (sb.ftime == '0) ? 32'd1 : 32'(sb.ftime);
      reach = (64'(sb.span) + 64'd2) * 64'(ftw) * 64'd2;
      if (reach > 64'hFFFF_FFFF)
         reach = 64'hFFFF_FFFF;
      sel = $urandom_range(0, 99);
      if (sel < 4)
         return sb.start_ms;
      else if (sel < 10)
         return $urandom_range(0, sb.start_ms);
      else if (sel < 18)
         return $urandom;
      else if (sel < 38)
         return sb.start_ms + $urandom_range(0, reach[31:0] / ftw) * ftw;
      else
         return sb.start_ms + $urandom_range(1, reach[31:0]);
   endfunction

   // Receiver: random stall bursts, plus one long hold on request.
   initial begin
      int hold_left;
      int stall_left;
      frame_result_type got;
      hold_left  = 0;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 8) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_current_frame, rsp_old_frame, rsp_back_lerp, rsp_done_res};
            sb.check_frame(got);
         end
      end
   end

   // Watchdog: end the run when no channel has moved for too long.
   initial idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("animation_frame_timer_tb: done, errors");
         $finish;
      end
   end

   initial begin
      sb                = new();
      gap_pct           = 0;
      stall_pct         = 0;
      calm              = 1'b0;
      long_hold_pending = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_now_ms        = '0;
      csr_valid         = 1'b0;
      csr_index         = afrm_pkg::REG_START_TIME;
      csr_wdata         = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: empty span, frame time one
      send_item(32'd5);
      idle_req(1);
      wait_drained();

      set_config(32'd1000, 16'd10, 16'd4, 16'd100, 1'b0);
      write_reg(REG_SPARE_LAST, 32'hFFFF_FFFF);
      send_item(32'd0);
      send_item(32'd1000);           // time equal to start
      send_item(32'd1001);
      send_item(32'd1100);           // exact frame boundary
      send_item(32'd1450);
      send_item(32'd1400);           // last frame
      send_item(32'd1550);           // past the end, hold
      send_item(32'hFFFF_FFFF);
      idle_req(1);
      wait_drained();

      write_reg(afrm_pkg::REG_LOOPING, 32'd1);
      send_item(32'd1550);           // wrap
      send_item(32'd1800);           // wrap back onto first
      idle_req(1);
      wait_drained();
      write_reg(REG_SPARE_FIRST, 32'h1234_5678);

      write_reg(afrm_pkg::REG_SPAN, 32'd0);
      send_item(32'd5000);           // empty span
      idle_req(1);
      wait_drained();
      write_reg(afrm_pkg::REG_SPAN, 32'd4);
      write_reg(afrm_pkg::REG_FRAME_TIME, 32'd0);
      send_item(32'd1003);           // zero frame time acts as one
      idle_req(1);
      wait_drained();

      set_config(32'hFFFF_FFFF, 16'd0, 16'd3, 16'd7, 1'b1);
      send_item(32'hFFFF_FFFF);
      send_item(32'd0);
      idle_req(1);
      wait_drained();

      set_config(32'd0, 16'hFFFF, 16'hFFFF, 16'd1, 1'b1);
      send_item(32'hFFFF_FFFF);
      send_item(32'h0000_FFFF);      // last frame at the top of the range
      send_item(32'd1);
      idle_req(1);
      wait_drained();
      write_reg(afrm_pkg::REG_FRAME_TIME, 32'h0000_FFFF);
      send_item(32'hFFFF_FFFF);
      send_item(32'h0000_FFFE);
      idle_req(1);
      wait_drained();
      write_reg(afrm_pkg::REG_LOOPING, 32'd0);
      send_item(32'hFFFF_FFFF);
      idle_req(1);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         calm = (phase >= PHASES - 3);
         case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 15;
            default: gap_pct = 40;
         endcase
         case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 15;
            default: stall_pct = 40;
         endcase
         if (calm) begin
            gap_pct   = 0;
            stall_pct = 0;
         end
         pick_config();
         if (phase == 3) begin
            // hold the receiver while the sender keeps pushing
            gap_pct = 0;
            long_hold_pending = 1'b1;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_item(pick_now());
            if (phase % 6 == 2 && i == PHASE_ITEMS / 2) begin
               idle_req(1);
               wait_drained();
            end else if (!calm && $urandom_range(0, 99) < gap_pct) begin
               idle_req($urandom_range(1, 8));
            end
         end
         idle_req(1);
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.close();
      if (sb.errors == 0)
         $display("animation_frame_timer_tb: done, clean");
      else
         $display("animation_frame_timer_tb: done, errors");
      $finish;
   end

endmodule

### filelist.f
rtl/core/afrm_pkg.sv
rtl/core/animation_frame_timer.sv
sim/animation_frame_timer_tb.sv
